>>> design/kms_pkg.sv
`default_nettype none
package kms_pkg;

  localparam logic       KIND_SCAN    = 1'b0;
  localparam logic       KIND_TICK    = 1'b1;
  localparam logic [5:0] ON_CODE      = 6'd30;
  localparam logic [5:0] NO_KEY       = 6'd63;
  localparam logic [15:0] BOUNCE_RESET = 16'd50;
  localparam int         RAW_ROWS     = 4;
  localparam int         RAW_W        = 14;
  localparam int         PACK_W       = 10;

  typedef struct packed {
    logic        kind;
    logic [13:0] row3_raw;
    logic [13:0] row2_raw;
    logic [13:0] row1_raw;
    logic [13:0] row0_raw;
    logic        on_pin;
  } req_t;

  typedef struct packed {
    logic       key_valid;
    logic [5:0] key_code;
    logic       none_down;
    logic       last_in_run;
  } rsp_t;

  typedef struct packed {
    logic       have_on;
    logic       single;
    logic [5:0] found;
    logic       none;
  } dec_t;

  // active-low port bits to packed column bits
  // columns 0,1 from bits 12,13; columns 2..8 from bits 0..6; column 9 from bit 11
  function automatic logic [PACK_W-1:0] pack_row(input logic [RAW_W-1:0] raw);
    logic [RAW_W-1:0] down;
    down = ~raw;
    return {down[11], down[6:0], down[13], down[12]};
  endfunction

endpackage
`default_nettype wire

>>> design/kms_decode.sv
`default_nettype none
module kms_decode #(
  parameter int ROWS       = 4,
  parameter int COLS       = 10,
  parameter int ON_BIT_POS = 40
) (
  input  wire kms_pkg::req_t        scan,
  input  wire logic [ON_BIT_POS:0]  held_map,
  output logic [ON_BIT_POS:0]       map,
  output kms_pkg::dec_t             dec
);
  import kms_pkg::*;

  localparam int READ_ROWS = (ROWS < RAW_ROWS) ? ROWS : RAW_ROWS;
  localparam int SCAN_W    = READ_ROWS * COLS;

  logic [RAW_W-1:0]      raw_rows [RAW_ROWS];
  logic [PACK_W-1:0]     packed_row;
  logic [ON_BIT_POS:0]   fresh;
  logic [SCAN_W-1:0]     keys;
  logic [5:0]            found;

  always_comb begin
    raw_rows[0] = scan.row0_raw;
    raw_rows[1] = scan.row1_raw;
    raw_rows[2] = scan.row2_raw;
    raw_rows[3] = scan.row3_raw;
  end

  always_comb begin
    map = '0;
    packed_row = '0;
    for (int r = 0; r < READ_ROWS; r++) begin
      packed_row = pack_row(raw_rows[r]);
      for (int c = 0; c < COLS; c++) begin
        map[r*COLS + c] = packed_row[c];
      end
    end
    map[ON_BIT_POS] = ~scan.on_pin;
  end

  assign fresh = map & ~held_map;
  assign keys  = fresh[SCAN_W-1:0];

  // lowest new key position
  always_comb begin
    found = '0;
    for (int p = SCAN_W - 1; p >= 0; p--) begin
      if (keys[p]) begin
        found = 6'(p);
      end
    end
  end

  always_comb begin
    dec.have_on = fresh[ON_BIT_POS];
    dec.single  = (keys != '0) && ((keys & (keys - SCAN_W'(1))) == '0);
    dec.found   = found;
    dec.none    = (map == '0);
  end

endmodule
`default_nettype wire

>>> design/kms_result_fifo.sv
`default_nettype none
module kms_result_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [1:0]    push_cnt,
  input  wire kms_pkg::rsp_t push0,
  input  wire kms_pkg::rsp_t push1,
  output logic [1:0]         room,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output kms_pkg::rsp_t      rsp
);
  import kms_pkg::*;

  rsp_t       q [2];
  rsp_t       q_next [2];
  logic [1:0] occ;
  logic [1:0] occ_next;
  logic       pop;
  logic [1:0] base;

  assign pop       = (occ != 2'd0) && rsp_ready;
  assign base      = occ - {1'b0, pop};
  assign room      = 2'd2 - base;
  assign occ_next  = base + push_cnt;
  assign rsp_valid = (occ != 2'd0);
  assign rsp       = q[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 2'd0;
    end else begin
      occ <= occ_next;
    end
  end

  always_comb begin
    q_next[0] = q[0];
    q_next[1] = q[1];
    if (pop) begin
      q_next[0] = q[1];
    end
    if (push_cnt != 2'd0) begin
      if (base[0]) begin
        q_next[1] = push0;
      end else begin
        q_next[0] = push0;
      end
    end
    if (push_cnt == 2'd2) begin
      q_next[1] = push1;
    end
  end

  always_ff @(posedge clk) begin
    q[0] <= q_next[0];
    q[1] <= q_next[1];
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push_cnt <= room)
    else $error("result beat pushed without room");

  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    occ != 2'd3)
    else $error("result queue occupancy out of range");

  a_head_held: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(q[0]))
    else $error("stalled result beat changed");

endmodule
`default_nettype wire

>>> design/keypad_matrix_scanner.sv
// keypad matrix scanner with ghost rejection and same-key bounce suppression
//
// req channel: one beat is either a keyboard scan (kind 0, four active-low row
// readings and the ON pin) or one timer tick (kind 1). rsp channel: a scan
// gives one or two beats (ON code first, then the key); last_in_run marks the
// final beat of a scan. A tick gives no beat. cfg channel: writes bounce_window,
// always ready; write it only while no scan is in flight.
//
// A req beat lands in an input register, where the decode runs on it; once there
// is room, the key state updates and its results enter a two-entry result queue,
// whose head register drives rsp. One req beat per cycle is sustained when each
// scan gives one rsp beat and the receiver does not stall; a scan with ON plus a
// key fills two queue entries. The queue depth sets the sustained rate.
//
// When the receiver stalls, results wait in the queue and the input register
// keeps taking beats until the queue lacks room for the pending item.
// Reset (rst, synchronous) empties the pipeline, clears the held key map and
// the bounce countdown, forgets the last key and sets bounce_window to 50.
`default_nettype none
module keypad_matrix_scanner #(
  parameter int ROWS       = 4,
  parameter int COLS       = 10,
  parameter int ON_BIT_POS = 40
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire kms_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output kms_pkg::rsp_t      rsp,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [15:0]   cfg_data
);
  import kms_pkg::*;

  req_t                 stage;
  logic                 stage_valid;
  logic                 advance;
  logic [ON_BIT_POS:0]  held_map;
  logic [ON_BIT_POS:0]  map;
  dec_t                 dec;
  logic [5:0]           last_accepted;
  logic [15:0]          bounce_count;
  logic [15:0]          count_dec;
  logic                 bounce_armed;
  logic [15:0]          bounce_window;
  logic                 is_tick;
  logic                 accept_key;
  logic [1:0]           need;
  logic [1:0]           room;
  logic [1:0]           push_cnt;
  rsp_t                 push0;
  rsp_t                 push1;

  kms_decode #(
    .ROWS       (ROWS),
    .COLS       (COLS),
    .ON_BIT_POS (ON_BIT_POS)
  ) u_decode (
    .scan     (stage),
    .held_map (held_map),
    .map      (map),
    .dec      (dec)
  );

  assign is_tick    = (stage.kind == KIND_TICK);
  assign accept_key = dec.single && (dec.found != last_accepted);
  assign count_dec  = (bounce_count != 16'd0) ? bounce_count - 16'd1 : 16'd0;

  always_comb begin
    if (is_tick) begin
      need = 2'd0;
    end else if (dec.have_on && accept_key) begin
      need = 2'd2;
    end else begin
      need = 2'd1;
    end
  end

  assign advance   = stage_valid && (room >= need);
  assign req_ready = !stage_valid || advance;
  assign push_cnt  = advance ? need : 2'd0;
  assign cfg_ready = 1'b1;

  always_comb begin
    push1.key_valid   = 1'b1;
    push1.key_code    = dec.found;
    push1.none_down   = dec.none;
    push1.last_in_run = 1'b1;
    if (dec.have_on) begin
      push0.key_valid   = 1'b1;
      push0.key_code    = ON_CODE;
      push0.none_down   = dec.none;
      push0.last_in_run = !accept_key;
    end else if (accept_key) begin
      push0 = push1;
    end else begin
      push0.key_valid   = 1'b0;
      push0.key_code    = 6'd0;
      push0.none_down   = dec.none;
      push0.last_in_run = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (req_ready) begin
      stage_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      stage <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bounce_window <= BOUNCE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      bounce_window <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_map      <= '0;
      last_accepted <= NO_KEY;
      bounce_count  <= 16'd0;
      bounce_armed  <= 1'b0;
    end else if (advance) begin
      if (is_tick) begin
        if (bounce_armed) begin
          bounce_count <= count_dec;
          if (count_dec == 16'd0) begin
            last_accepted <= NO_KEY;
            bounce_armed  <= 1'b0;
          end
        end
      end else begin
        held_map <= map;
        if (accept_key) begin
          last_accepted <= dec.found;
          bounce_count  <= bounce_window;
          bounce_armed  <= 1'b1;
        end
      end
    end
  end

  kms_result_fifo u_result_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_cnt  (push_cnt),
    .push0     (push0),
    .push1     (push1),
    .room      (room),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  a_forget_disarms: assert property (@(posedge clk) disable iff (rst)
    !bounce_armed |-> last_accepted == NO_KEY)
    else $error("last key kept without a running countdown");

  a_accept_arms: assert property (@(posedge clk) disable iff (rst)
    advance && !is_tick && accept_key |=> bounce_armed && last_accepted != NO_KEY)
    else $error("accepted key did not arm the countdown");

  a_tick_silent: assert property (@(posedge clk) disable iff (rst)
    advance && is_tick |-> push_cnt == 2'd0)
    else $error("tick produced a result beat");

endmodule
`default_nettype wire
